[src/sha1_entropy_pool_prng_defines.svh]
// Assertion helpers for the hashed entropy pool generator
`ifndef SHA1_ENTROPY_POOL_PRNG_DEFINES_SVH
`define SHA1_ENTROPY_POOL_PRNG_DEFINES_SVH
`ifndef SYNTHESIS
`define SEP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");
`define SEP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error("assertion failed");
`else
`define SEP_ASSERT(lbl, clk, rstn, prop)
`define SEP_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

[src/sep_pkg.sv]
`timescale 1ns / 1ps
package sep_pkg;
  localparam int unsigned Step = 20;
  localparam int unsigned Span = 64;
  localparam int unsigned PremixLen = 256;
  localparam int unsigned TailLen = 128;
  localparam logic [19:0] CountMax = 20'hFFFFF;
  localparam logic [7:0] AllOnes = 8'hff;

  typedef logic [159:0] sha_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // one SHA-1 round: state {a,b,c,d,e}, round index, schedule word
  function automatic sha_state_t sha_round(input sha_state_t s, input logic [6:0] r,
                                           input logic [31:0] w);
    logic [31:0] a, b, c, d, e, f, k, t;
    a = s[159:128]; b = s[127:96]; c = s[95:64]; d = s[63:32]; e = s[31:0];
    if (r < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (r < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t = rotl(a, 5) + f + e + k + w;
    sha_round = {t, a, rotl(b, 30), c, d};
  endfunction

  localparam sha_state_t ShaInit =
    {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
endpackage

[src/sha1_entropy_pool_prng.sv]
`timescale 1ns / 1ps
// Hashed entropy pool random generator.
// Input beats on s_axis (tuser = req_type) carry seed chunks or request
// chunks; one result beat per input beat leaves on m_axis. Configuration:
// cfg_valid_i/cfg_ready_o write entropy_threshold (bytes), always ready; write
// it only while no beat is in flight.
// The pool lives in a byte-wide synchronous RAM; all work is a sequencer
// over that one port, one byte read or written per cycle.
// Work per chunk: a seed chunk hashes 84+len bytes (2 SHA blocks, 80 rounds
// each) plus 20 read-modify-write folds; a wrap of the pool position adds a
// full-pool invert. A request chunk reads and rewrites len bytes; the first
// one adds the pre-mix (SHA over 256 bytes, a read-xor-write word sweep,
// SHA over the tail), the last one a full-pool sweep.
// Throughput: one chunk at a time. The next beat may be taken while the
// previous result still waits in the output register; a finished chunk then
// holds until a stalled receiver raises m_axis_tready and frees the register.
// After reset a clearing pass zeroes the pool, during which s_axis_tready
// stays low.
`include "sha1_entropy_pool_prng_defines.svh"
module sha1_entropy_pool_prng #(
  parameter int unsigned POOL_BYTES = 4100
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // seed_low[63:0], seed_mid[127:64], seed_high[159:128], chunk_len[164:160],
  // first_chunk[165], last_chunk[166], entropy_add[187:167], zero pad
  input  logic [191:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[0], rand_low[64:1], rand_mid[128:65], rand_high[160:129],
  // out_len[165:161], seeded_flag[166], entropy_bits[182:167], zero pad
  output logic [183:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [12:0]  cfg_data_i
);
  localparam int unsigned AW = $clog2(POOL_BYTES);
  localparam int unsigned NWords = POOL_BYTES / 4;
  localparam int unsigned EW = $clog2(POOL_BYTES * 256 + 1);
  localparam logic [AW-1:0] LastAddr = AW'(POOL_BYTES - 1);
  localparam logic [31:0] WordCnt = 32'(NWords);

  // ---------------- state machine ----------------
  typedef enum logic [16:0] {
    S_CLEAR  = 17'h00001, S_IDLE   = 17'h00002, S_HLOAD  = 17'h00004,
    S_HROUND = 17'h00008, S_HDONE  = 17'h00010, S_FOLD   = 17'h00020,
    S_INVERT = 17'h00040, S_MIXRD  = 17'h00080, S_MIXWR  = 17'h00100,
    S_REQ    = 17'h00200, S_POST   = 17'h00400, S_FIN    = 17'h00800,
    S_OUT    = 17'h01000, S_PREDIG = 17'h02000, S_SEEDH  = 17'h04000,
    S_TAILH  = 17'h08000, S_PREH   = 17'h10000
  } state_e;

  typedef enum logic [1:0] {
    H_SEED = 2'd0, H_PRE = 2'd1, H_TAIL = 2'd2
  } hkind_e;

  state_e state_q, state_d;

  // pool RAM, one byte port
  logic [7:0] pool_mem [POOL_BYTES];
  logic [AW-1:0] ram_addr;
  logic ram_we;
  logic [7:0] ram_wdata, ram_rdata;
  always_ff @(posedge clk_i) begin
    if (ram_we) pool_mem[ram_addr] <= ram_wdata;
    ram_rdata <= pool_mem[ram_addr];
  end

  // control registers
  logic [AW-1:0] pos_q, pos_d;
  logic [EW-1:0] ent_q, ent_d;
  logic seeded_q, seeded_d;
  logic [19:0] cnt_q, cnt_d;
  logic [12:0] thr_q;
  logic [159:0] rdig_q, rdig_d;
  // current chunk
  logic [159:0] seed_q, seed_d;
  logic [4:0] len_q, len_d;
  logic last_q, last_d, typ_q, typ_d;
  logic [20:0] eadd_q, eadd_d;
  // hash engine
  hkind_e hk_q, hk_d;
  logic [511:0] blk_q, blk_d;     // 16 schedule words, w[t] in [511:480]
  logic [159:0] hs_q, hs_d;       // working vars
  logic [159:0] hh_q, hh_d;       // chaining value
  logic [7:0] mlen_q, mlen_d;     // total message length (bytes)
  logic [8:0] bcnt_q, bcnt_d;     // message byte index
  logic [6:0] rnd_q, rnd_d;
  logic [12:0] sidx_q, sidx_d;    // generic sweep counter
  logic [2:0] sub_q, sub_d;       // byte within word / pipeline phase
  logic [31:0] wacc_q, wacc_d;
  logic [AW-1:0] base_q, base_d;
  logic [159:0] dig_q, dig_d;     // seed or premix digest
  logic [159:0] rand_q, rand_d;
  logic [4:0] olen_q, olen_d;
  logic stat_q, stat_d;
  logic [183:0] obuf_q, obuf_d;
  logic ovalid_q, ovalid_d;
  logic rd_pend_q, rd_pend_d;
  // (wi - 5) mod 5 by repeated compare is too long; track phase separately
  logic [2:0] ph_q, ph_d;

  // address modulo pool size for sums below 2*POOL_BYTES
  function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
    wrap = (a >= (AW+1)'(POOL_BYTES)) ? AW'(a - (AW+1)'(POOL_BYTES)) : a[AW-1:0];
  endfunction

  // byte index of message for the current hash
  logic [7:0] msg_byte;
  logic [AW-1:0] msg_addr;
  logic msg_from_ram;
  always_comb begin
    msg_from_ram = 1'b0;
    msg_addr = '0;
    msg_byte = '0;
    case (hk_q)
      H_SEED: begin
        if (bcnt_q < 9'd84) begin
          msg_from_ram = 1'b1;
          msg_addr = wrap({1'b0, base_q} + (AW+1)'(bcnt_q));
        end else begin
          msg_byte = 8'(seed_q >> {bcnt_q[4:0] - 5'd20, 3'b000});
        end
      end
      H_PRE: begin
        msg_from_ram = 1'b1;
        msg_addr = AW'(bcnt_q);
      end
      H_TAIL: begin
        msg_from_ram = 1'b1;
        msg_addr = AW'(POOL_BYTES - sep_pkg::TailLen) + AW'(bcnt_q);
      end
      default: ;
    endcase
  end

  // padded message byte at global offset
  logic [8:0] goff;
  logic [7:0] pad_byte;
  logic [63:0] bitlen;
  always_comb begin
    bitlen = 64'(mlen_q) << 3;
    if (goff == 9'(mlen_q)) pad_byte = 8'h80;
    else pad_byte = 8'h00;
  end

  // premix index helpers; digest word k sits at dig_q[32k +: 32]
  logic [12:0] wi;   // target word index
  logic [12:0] src;  // source word index
  logic [31:0] dsel;
  always_comb begin
    wi = sidx_q;
    if (wi < 13'd5) begin
      case (wi[2:0])
        3'd0: begin src = 13'(NWords - 1); dsel = dig_q[159:128]; end
        3'd1: begin src = 13'(NWords - 4); dsel = dig_q[31:0]; end
        3'd2: begin src = 13'(NWords - 2); dsel = dig_q[95:64]; end
        3'd3: begin src = 13'(NWords - 3); dsel = dig_q[63:32]; end
        default: begin src = 13'(NWords - 5); dsel = dig_q[127:96]; end
      endcase
    end else begin
      src = wi - 13'd5;
      case (ph_q)
        3'd0: dsel = dig_q[127:96];
        3'd1: dsel = dig_q[95:64];
        3'd2: dsel = dig_q[63:32];
        3'd3: dsel = dig_q[31:0];
        default: dsel = dig_q[159:128];
      endcase
    end
  end

  // digest bytes: out byte i = h[i/4] >> (24 - 8*(i%4)), big endian per word
  function automatic logic [159:0] dig_le(input logic [159:0] h);
    logic [159:0] r;
    for (int i = 0; i < 20; i++) r[8*i +: 8] = h[159 - 8*i -: 8];
    dig_le = r;
  endfunction
  // chaining value plus working vars at the end of a block
  logic [159:0] hsum;
  assign hsum = {hh_q[159:128] + hs_q[159:128], hh_q[127:96] + hs_q[127:96],
                 hh_q[95:64] + hs_q[95:64], hh_q[63:32] + hs_q[63:32],
                 hh_q[31:0] + hs_q[31:0]};

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    rotl1 = {x[30:0], x[31]};
  endfunction
  logic [31:0] wnext;
  assign wnext = rotl1(blk_q[511-13*32 -: 32] ^ blk_q[511-8*32 -: 32] ^
                       blk_q[511-2*32 -: 32] ^ blk_q[511 -: 32]);

  logic [AW:0] rpos;
  logic [21:0] ent_add_sum;
  logic [27:0] sub_amt;

  always_comb begin
    state_d = state_q; pos_d = pos_q; ent_d = ent_q; seeded_d = seeded_q;
    cnt_d = cnt_q; rdig_d = rdig_q; seed_d = seed_q; len_d = len_q;
    last_d = last_q; typ_d = typ_q; eadd_d = eadd_q;
    hk_d = hk_q; blk_d = blk_q; hs_d = hs_q; hh_d = hh_q; mlen_d = mlen_q;
    bcnt_d = bcnt_q; rnd_d = rnd_q; sidx_d = sidx_q; sub_d = sub_q;
    wacc_d = wacc_q; base_d = base_q; dig_d = dig_q; rand_d = rand_q;
    olen_d = olen_q; stat_d = stat_q; obuf_d = obuf_q; ovalid_d = ovalid_q;
    rd_pend_d = rd_pend_q; ph_d = ph_q;
    ram_addr = '0; ram_we = 1'b0; ram_wdata = '0;
    goff = '0;
    rpos = '0; ent_add_sum = '0; sub_amt = '0;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_addr = sidx_q[AW-1:0]; ram_we = 1'b1; ram_wdata = '0;
        sidx_d = sidx_q + 13'd1;
        if (sidx_q[AW-1:0] == LastAddr) begin
          state_d = S_IDLE; sidx_d = '0;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          typ_d = s_axis_tuser;
          seed_d = s_axis_tdata[159:0];
          len_d = (s_axis_tdata[164:160] > 5'd20) ? 5'd20 : s_axis_tdata[164:160];
          last_d = s_axis_tdata[166];
          eadd_d = s_axis_tdata[187:167];
          rand_d = '0; olen_d = '0; stat_d = 1'b0;
          if (!s_axis_tuser) begin
            if (s_axis_tdata[164:160] != 5'd0) begin
              hk_d = H_SEED;
              mlen_d = 8'd84 + 8'((s_axis_tdata[164:160] > 5'd20) ? 5'd20
                                    : s_axis_tdata[164:160]);
              base_d = (pos_q == '0) ? AW'(POOL_BYTES - sep_pkg::Step)
                       : AW'(pos_q - AW'(sep_pkg::Step));
              state_d = S_SEEDH;
            end else begin
              state_d = S_FIN;
            end
          end else if (!seeded_q) begin
            stat_d = 1'b1; state_d = S_FIN;
          end else if (s_axis_tdata[165]) begin
            hk_d = H_PRE; mlen_d = '0; // 256 encoded via hk
            state_d = S_PREH;
          end else begin
            sidx_d = '0; state_d = S_REQ;
          end
        end
      end
      // start a hash
      S_SEEDH, S_PREH, S_TAILH: begin
        hh_d = sep_pkg::ShaInit; bcnt_d = '0; sub_d = '0; rd_pend_d = 1'b0;
        state_d = S_HLOAD;
      end
      // gather 64 bytes of the padded message into blk_q
      S_HLOAD: begin
        goff = bcnt_q;
        if (rd_pend_q) begin
          blk_d = {blk_q[503:0], ram_rdata};
          rd_pend_d = 1'b0;
          bcnt_d = bcnt_q + 9'd1;
          if (bcnt_q[5:0] == 6'd63) begin
            hs_d = hh_q; rnd_d = '0; state_d = S_HROUND;
          end
        end else if (hk_q == H_PRE || hk_q == H_TAIL) begin
          // message length 256 or 128: full blocks, then one pad block
          if (bcnt_q < ((hk_q == H_PRE) ? 9'd256 : 9'd128)) begin
            ram_addr = msg_addr; rd_pend_d = 1'b1;
          end else begin
            if (bcnt_q[5:0] == 6'd0) blk_d = {blk_q[503:0], 8'h80};
            else if (bcnt_q[5:0] == 6'd62)
              blk_d = {blk_q[503:0], (hk_q == H_PRE) ? 8'h08 : 8'h04};
            else blk_d = {blk_q[503:0], 8'h00};
            bcnt_d = bcnt_q + 9'd1;
            if (bcnt_q[5:0] == 6'd63) begin
              hs_d = hh_q; rnd_d = '0; state_d = S_HROUND;
            end
          end
        end else begin
          if (bcnt_q < 9'(mlen_q) && msg_from_ram) begin
            ram_addr = msg_addr; rd_pend_d = 1'b1;
          end else begin
            if (bcnt_q < 9'(mlen_q)) blk_d = {blk_q[503:0], msg_byte};
            else if (bcnt_q >= 9'd120) blk_d = {blk_q[503:0],
                       8'(bitlen >> {3'd0, 9'd127 - bcnt_q, 3'd0})};
            else blk_d = {blk_q[503:0], pad_byte};
            bcnt_d = bcnt_q + 9'd1;
            if (bcnt_q[5:0] == 6'd63) begin
              hs_d = hh_q; rnd_d = '0; state_d = S_HROUND;
            end
          end
        end
      end
      S_HROUND: begin
        hs_d = sep_pkg::sha_round(hs_q, rnd_q, blk_q[511 -: 32]);
        blk_d = {blk_q[479:0], wnext};
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = S_HDONE;
      end
      S_HDONE: begin
        hh_d = hsum;
        if ((hk_q == H_SEED && bcnt_q == 9'd128) ||
            (hk_q == H_PRE && bcnt_q == 9'd320) ||
            (hk_q == H_TAIL && bcnt_q == 9'd192)) begin
          case (hk_q)
            H_SEED: begin
              dig_d = dig_le(hsum); sidx_d = '0; sub_d = '0; state_d = S_FOLD;
            end
            H_PRE: begin
              dig_d = dig_le(hsum); sidx_d = '0; sub_d = '0; ph_d = '0;
              state_d = S_MIXRD;
            end
            default: begin
              rdig_d = dig_le(hsum); cnt_d = '0; sidx_d = '0; sub_d = '0;
              state_d = S_REQ;
            end
          endcase
        end else begin
          state_d = S_HLOAD;
        end
      end
      // xor digest into pool at position: read, then write
      S_FOLD: begin
        ram_addr = wrap({1'b0, pos_q} + (AW+1)'(sidx_q[4:0]));
        if (!sub_q[0]) begin
          sub_d = 3'd1;
        end else begin
          ram_we = 1'b1;
          ram_wdata = ram_rdata ^ dig_q[8*sidx_q[4:0] +: 8];
          sub_d = '0;
          sidx_d = sidx_q + 13'd1;
          if (sidx_q == 13'(sep_pkg::Step - 1)) begin
            rpos = {1'b0, pos_q} + (AW+1)'(sep_pkg::Step);
            pos_d = wrap(rpos);
            sidx_d = '0;
            state_d = (wrap(rpos) == '0) ? S_INVERT : S_FIN;
          end
        end
      end
      S_INVERT: begin
        ram_addr = sidx_q[AW-1:0];
        if (!sub_q[0]) begin
          sub_d = 3'd1;
        end else begin
          ram_we = 1'b1; ram_wdata = ram_rdata ^ sep_pkg::AllOnes;
          sub_d = '0; sidx_d = sidx_q + 13'd1;
          if (sidx_q[AW-1:0] == LastAddr) state_d = S_FIN;
        end
      end
      // premix: read source word (4 bytes), then read-xor-write target word
      S_MIXRD: begin
        // sub 0..3 issue reads, data arrives in the following cycle
        ram_addr = AW'((32'(src) << 2) + 32'(sub_q[1:0]));
        if (sub_q != 3'd0) wacc_d = {ram_rdata, wacc_q[31:8]};
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd4) begin
          wacc_d = {ram_rdata, wacc_q[31:8]} ^ dsel;
          sub_d = '0; state_d = S_MIXWR;
        end
      end
      S_MIXWR: begin
        ram_addr = AW'((32'(wi) << 2) + 32'(sub_q[2:1]));
        if (sub_q[0]) begin
          ram_we = 1'b1;
          ram_wdata = ram_rdata ^ wacc_q[8*sub_q[2:1] +: 8];
        end
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd7) begin
          sub_d = '0;
          sidx_d = sidx_q + 13'd1;
          if (sidx_q >= 13'd5) ph_d = (ph_q == 3'd4) ? 3'd0 : ph_q + 3'd1;
          // loop runs while i+4 < W at block starts
          if (sidx_q + 13'd1 >= 13'((NWords / 5) * 5) || sidx_q + 13'd1 >= 13'(NWords)) begin
            hk_d = H_TAIL; state_d = S_TAILH;
          end else begin
            state_d = S_MIXRD;
          end
        end
      end
      // request bytes: read, then write xor digest
      S_REQ: begin
        if (sidx_q[4:0] >= len_q) begin
          olen_d = len_q;
          if (len_q != 5'd0) begin
            rpos = {1'b0, pos_q} + (AW+1)'(sep_pkg::Step);
            pos_d = wrap(rpos);
          end
          cnt_d = ((21'(cnt_q) + 21'(len_q)) > 21'(sep_pkg::CountMax)) ? sep_pkg::CountMax
                  : 20'(21'(cnt_q) + 21'(len_q));
          sidx_d = '0; sub_d = '0;
          state_d = last_q ? S_POST : S_FIN;
        end else begin
          ram_addr = wrap({1'b0, pos_q} + (AW+1)'(sidx_q[4:0]));
          if (!sub_q[0]) begin
            sub_d = 3'd1;
          end else begin
            rand_d[8*sidx_q[4:0] +: 8] = ram_rdata;
            ram_we = 1'b1; ram_wdata = ram_rdata ^ rdig_q[8*sidx_q[4:0] +: 8];
            sub_d = '0; sidx_d = sidx_q + 13'd1;
          end
        end
      end
      S_POST: begin
        ram_addr = sidx_q[AW-1:0];
        if (!sub_q[0]) begin
          sub_d = 3'd1;
        end else begin
          ram_we = 1'b1; ram_wdata = ram_rdata ^ WordCnt[8*sidx_q[1:0] +: 8];
          sub_d = '0; sidx_d = sidx_q + 13'd1;
          if (sidx_q[AW-1:0] == LastAddr) begin
            sub_amt = {cnt_q, 8'd0};
            ent_d = (28'(ent_q) > sub_amt) ? EW'(28'(ent_q) - sub_amt) : '0;
            cnt_d = '0;
            state_d = S_OUT;
          end
        end
      end
      S_FIN: begin
        if (!typ_q && last_q) begin
          ent_add_sum = 22'(ent_q) + 22'(eadd_q);
          ent_d = (ent_add_sum > 22'(POOL_BYTES * 256)) ? EW'(POOL_BYTES * 256)
                  : EW'(ent_add_sum);
        end
        state_d = S_OUT;
      end
      // hand the result over once the output register is free
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          if (!typ_q && last_q && 21'(ent_q) >= {thr_q, 8'd0}) seeded_d = 1'b1;
          obuf_d = {1'b0, 16'(ent_q >> 5), (!typ_q && last_q &&
                    21'(ent_q) >= {thr_q, 8'd0}) ? 1'b1 : seeded_q,
                    olen_q, rand_q, stat_q};
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; pos_q <= '0; ent_q <= '0; seeded_q <= 1'b0;
      cnt_q <= '0; thr_q <= '0; rdig_q <= '0; ovalid_q <= 1'b0;
      sidx_q <= '0; sub_q <= '0; rd_pend_q <= 1'b0; ph_q <= '0;
      hk_q <= H_SEED;
    end else begin
      state_q <= state_d; pos_q <= pos_d; ent_q <= ent_d; seeded_q <= seeded_d;
      cnt_q <= cnt_d; rdig_q <= rdig_d; ovalid_q <= ovalid_d;
      sidx_q <= sidx_d; sub_q <= sub_d; rd_pend_q <= rd_pend_d; ph_q <= ph_d;
      hk_q <= hk_d;
      if (cfg_valid_i) thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d; len_q <= len_d; last_q <= last_d;
    typ_q <= typ_d; eadd_q <= eadd_d; blk_q <= blk_d; hs_q <= hs_d;
    hh_q <= hh_d; mlen_q <= mlen_d; bcnt_q <= bcnt_d; rnd_q <= rnd_d;
    wacc_q <= wacc_d; base_q <= base_d; dig_q <= dig_d; rand_q <= rand_d;
    olen_q <= olen_d; stat_q <= stat_d; obuf_q <= obuf_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = obuf_q;
  assign cfg_ready_o = 1'b1;

  `SEP_ASSERT(a_len_range, clk_i, rst_ni, !m_axis_tvalid || (m_axis_tdata[165:161] <= 5'd20))
  `SEP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SEP_ASSERT_NEXT(a_seed_sticky, clk_i, rst_ni, seeded_q, seeded_q)
endmodule

[dv/pool_scoreboard.sv]
`timescale 1ns / 1ps
// Watches the stream and config channels of the entropy pool generator,
// predicts every result beat and compares it field by field.
module pool_scoreboard #(
  parameter int unsigned POOL = 4100
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [191:0] s_data_i,
  input  logic         s_user_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [183:0] m_data_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [12:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  localparam int unsigned Words = POOL / 4;

  typedef struct packed {
    logic         status;
    logic [159:0] rnd;
    logic [4:0]   len;
    logic         seeded;
    logic [15:0]  ent_bits;
  } pool_result_t;

  // mirrored block state
  logic [7:0]   pool_mem [POOL];
  int unsigned  cursor;
  logic [31:0]  entropy;
  logic         is_seeded;
  logic [159:0] req_hash;
  logic [19:0]  req_bytes;
  logic [12:0]  threshold;

  pool_result_t expected_q[$];

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one SHA-1 compression, byte 0 of the block in the top bits
  function automatic logic [159:0] compress(logic [159:0] hs, logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = hs;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {hs[159:128] + a, hs[127:96] + b, hs[95:64] + c, hs[63:32] + d, hs[31:0] + e};
  endfunction

  // digest byte i sits at [159-8i -: 8]
  function automatic logic [159:0] digest_of(logic [7:0] msg[$]);
    logic [159:0] hs;
    logic [511:0] blk;
    logic [63:0]  nbits;
    hs = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    nbits = 64'(msg.size()) * 8;
    msg.push_back(8'h80);
    while (msg.size() % 64 != 56) msg.push_back(8'h00);
    for (int i = 7; i >= 0; i--) msg.push_back(nbits[8*i +: 8]);
    for (int base = 0; base < msg.size(); base += 64) begin
      for (int j = 0; j < 64; j++) blk[511 - 8 * j -: 8] = msg[base + j];
      hs = compress(hs, blk);
    end
    return hs;
  endfunction

  function automatic logic [7:0] dbyte(logic [159:0] dg, int i);
    return dg[159 - 8 * i -: 8];
  endfunction

  function automatic logic [31:0] dword(logic [159:0] dg, int k);
    return {dbyte(dg, 4*k+3), dbyte(dg, 4*k+2), dbyte(dg, 4*k+1), dbyte(dg, 4*k)};
  endfunction

  function automatic logic [31:0] pool_word(int unsigned wi);
    int unsigned b;
    b = (wi * 4) % POOL;
    return {pool_mem[b+3], pool_mem[b+2], pool_mem[b+1], pool_mem[b]};
  endfunction

  task automatic flip_word(int unsigned wi, logic [31:0] v);
    int unsigned b;
    b = (wi * 4) % POOL;
    for (int i = 0; i < 4; i++) pool_mem[b+i] ^= v[8*i +: 8];
  endtask

  // whole-pool hash mix ahead of a request call
  task automatic request_premix();
    logic [7:0]   msg[$];
    logic [159:0] dg;
    for (int i = 0; i < 256; i++) msg.push_back(pool_mem[i]);
    dg = digest_of(msg);
    flip_word(0, pool_word(Words - 1) ^ dword(dg, 4));
    flip_word(1, pool_word(Words - 4) ^ dword(dg, 0));
    flip_word(2, pool_word(Words - 2) ^ dword(dg, 2));
    flip_word(3, pool_word(Words - 3) ^ dword(dg, 1));
    flip_word(4, pool_word(Words - 5) ^ dword(dg, 3));
    for (int unsigned i = 5; i + 4 < Words; i += 5) begin
      flip_word(i,     pool_word(i - 5) ^ dword(dg, 3));
      flip_word(i + 1, pool_word(i - 4) ^ dword(dg, 2));
      flip_word(i + 2, pool_word(i - 3) ^ dword(dg, 1));
      flip_word(i + 3, pool_word(i - 2) ^ dword(dg, 0));
      flip_word(i + 4, pool_word(i - 1) ^ dword(dg, 4));
    end
    msg.delete();
    for (int i = POOL - 128; i < POOL; i++) msg.push_back(pool_mem[i]);
    req_hash = digest_of(msg);
  endtask

  task automatic predict_chunk(input logic is_req, input logic [191:0] d,
                               output pool_result_t r);
    logic [7:0]   msg[$];
    logic [159:0] dg;
    int unsigned  n, prev, cap, sub;
    logic         first, last;
    n = d[164:160];
    first = d[165];
    last = d[166];
    if (n > 20) n = 20;
    r = '0;
    if (!is_req) begin
      // seed fold: previous step, 64 bytes from cursor, chunk bytes
      if (n > 0) begin
        prev = (cursor == 0) ? POOL - 20 : cursor - 20;
        for (int i = 0; i < 20; i++) msg.push_back(pool_mem[(prev + i) % POOL]);
        for (int i = 0; i < 64; i++) msg.push_back(pool_mem[(cursor + i) % POOL]);
        for (int i = 0; i < n; i++) msg.push_back(d[8*i +: 8]);
        dg = digest_of(msg);
        for (int i = 0; i < 20; i++) pool_mem[(cursor + i) % POOL] ^= dbyte(dg, i);
        cursor = (cursor + 20) % POOL;
        if (cursor == 0)
          for (int i = 0; i < POOL; i++) pool_mem[i] = ~pool_mem[i];
      end
      if (last) begin
        cap = POOL * 256;
        entropy = entropy + d[187:167];
        if (entropy > cap) entropy = cap;
        if (entropy >= 32'(threshold) * 256) is_seeded = 1'b1;
      end
      n = 0;
    end else if (!is_seeded) begin
      r.status = 1'b1;
      n = 0;
    end else begin
      if (first) begin
        request_premix();
        req_bytes = '0;
      end
      if (n > 0) begin
        for (int i = 0; i < n; i++) begin
          r.rnd[8*i +: 8] = pool_mem[(cursor + i) % POOL];
          pool_mem[(cursor + i) % POOL] ^= dbyte(req_hash, i);
        end
        cursor = (cursor + 20) % POOL;
      end
      req_bytes = (32'(req_bytes) + n > 32'hFFFFF) ? 20'hFFFFF : req_bytes + 20'(n);
      if (last) begin
        sub = 32'(req_bytes) * 256;
        for (int unsigned i = 0; i < Words; i++) flip_word(i, Words);
        entropy = (entropy > sub) ? entropy - sub : 0;
        req_bytes = '0;
      end
    end
    r.len = n[4:0];
    r.seeded = is_seeded;
    r.ent_bits = entropy[20:5];
  endtask

  task automatic report(string field, logic [159:0] got, logic [159:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t p, g;
    if (!rst_ni) begin
      for (int i = 0; i < POOL; i++) pool_mem[i] = '0;
      cursor = 0;
      entropy = 0;
      is_seeded = 1'b0;
      req_hash = '0;
      req_bytes = '0;
      threshold = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold = cfg_data_i;
      if (s_valid_i && s_ready_i) begin
        predict_chunk(s_user_i, s_data_i, p);
        expected_q.push_back(p);
      end
      if (m_valid_i && m_ready_i) begin
        g.status = m_data_i[0];
        g.rnd = m_data_i[160:1];
        g.len = m_data_i[165:161];
        g.seeded = m_data_i[166];
        g.ent_bits = m_data_i[182:167];
        if (expected_q.size() == 0) begin
          report("unexpected result beat", m_data_i[160:1], '0);
        end else begin
          p = expected_q.pop_front();
          if (g.status !== p.status) report("status", g.status, p.status);
          if (g.rnd !== p.rnd) report("random bytes", g.rnd, p.rnd);
          if (g.len !== p.len) report("out_len", g.len, p.len);
          if (g.seeded !== p.seeded) report("seeded_flag", g.seeded, p.seeded);
          if (g.ent_bits !== p.ent_bits) report("entropy_bits", g.ent_bits, p.ent_bits);
        end
      end
      pending_o = expected_q.size();
    end
  end
endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [183:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [12:0]  cfg_data_i = '0;
  int           fail_count;
  int           pending;
  int           tx_idle = 0;
  int           rx_idle = 0;
  int           sent = 0;

  localparam logic SEED = 1'b0;
  localparam logic REQUEST = 1'b1;

  sha1_entropy_pool_prng #(.POOL_BYTES(4100)) dut (.*);

  pool_scoreboard #(.POOL(4100)) scoreboard (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side backpressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= rx_idle);

  initial begin
    #40_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic send_chunk(logic kind, logic [159:0] seed, logic [4:0] len,
                            logic first, logic last, logic [20:0] ent);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, ent, last, first, len, seed};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
  endtask

  // idle point: drain every result, then write the threshold
  task automatic set_threshold(logic [12:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [159:0] rand_seed();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] rand_len();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'($urandom_range(21, 31));
      2, 3: return 5'd20;
      default: return 5'($urandom_range(1, 19));
    endcase
  endfunction

  function automatic logic [20:0] rand_entropy();
    case ($urandom_range(9))
      0: return 21'($urandom);
      1, 2, 3: return 21'($urandom_range(0, 60000));
      default: return 21'($urandom_range(0, 4000));
    endcase
  endfunction

  // random calls; full-pool request mixes kept rare
  task automatic random_phase(int count, int tx, int rx);
    int start, r, chunks;
    tx_idle = tx;
    rx_idle = rx;
    start = sent;
    while (sent - start < count) begin
      r = $urandom_range(999);
      if (r < 620) begin
        chunks = $urandom_range(1, 4);
        for (int c = 0; c < chunks; c++)
          send_chunk(SEED, rand_seed(), rand_len(), c == 0, c == chunks - 1, rand_entropy());
      end else if (r < 635) begin
        chunks = $urandom_range(1, 4);
        for (int c = 0; c < chunks; c++)
          send_chunk(REQUEST, rand_seed(), rand_len(), c == 0, c == chunks - 1,
                     rand_entropy());
      end else if (r < 650) begin
        // broken call: only one of the marks
        r = $urandom_range(1);
        send_chunk(REQUEST, rand_seed(), rand_len(), r[0], !r[0], rand_entropy());
      end else if (r < 850) begin
        chunks = $urandom_range(1, 3);
        for (int c = 0; c < chunks; c++)
          send_chunk(REQUEST, rand_seed(), rand_len(), 1'b0, 1'b0, rand_entropy());
      end else begin
        r = $urandom_range(3);
        send_chunk(SEED, rand_seed(), rand_len(), r[0], r[1], rand_entropy());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: refusals until the highest threshold is met, then requests
    set_threshold(13'd4100);
    send_chunk(REQUEST, '1, 5'd20, 1'b1, 1'b1, '0);
    send_chunk(SEED, '1, 5'd0, 1'b1, 1'b1, '0);
    send_chunk(SEED, '1, 5'd20, 1'b1, 1'b0, '1);
    send_chunk(SEED, '0, 5'd1, 1'b0, 1'b1, 21'd256);
    send_chunk(REQUEST, '0, 5'd7, 1'b0, 1'b0, '0);
    send_chunk(SEED, '1, 5'd31, 1'b1, 1'b1, 21'd1049600);
    send_chunk(SEED, '0, 5'd5, 1'b1, 1'b1, '1);
    send_chunk(REQUEST, '0, 5'd0, 1'b1, 1'b0, '0);
    send_chunk(REQUEST, '1, 5'd20, 1'b0, 1'b0, '1);
    send_chunk(REQUEST, '0, 5'd31, 1'b0, 1'b0, '0);
    send_chunk(REQUEST, '0, 5'd7, 1'b0, 1'b1, '0);
    send_chunk(REQUEST, '0, 5'd20, 1'b1, 1'b1, '0);
    send_chunk(REQUEST, '0, 5'd0, 1'b1, 1'b1, '0);
    send_chunk(SEED, 160'h0123456789abcdef_fedcba9876543210_a5a5a5a5, 5'd19,
               1'b0, 1'b0, '0);

    random_phase(570, 38, 67);
    set_threshold(13'd0);
    random_phase(570, 67, 38);
    set_threshold(13'($urandom_range(1, 4099)));
    random_phase(570, 0, 0);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
